// ----- sv/link_timer_retry_fsm_assert.svh -----
// Assertion macros shared by the link timer and retry controller.
`ifndef LINK_TIMER_RETRY_FSM_ASSERT_SVH
`define LINK_TIMER_RETRY_FSM_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LTR_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("link timer assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define LTR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("link timer assertion failed");

`endif

// ----- sv/ltr_pkg.sv -----
`timescale 1ns / 1ps
// Types and codes shared by the link timer and retry controller.
package ltr_pkg;

   // Timer and sync event codes.
   localparam logic [2:0] REQ_HEARTBEAT = 3'd0;
   localparam logic [2:0] REQ_T1        = 3'd1;
   localparam logic [2:0] REQ_T2        = 3'd2;
   localparam logic [2:0] REQ_T3        = 3'd3;
   localparam logic [2:0] REQ_IDLE      = 3'd4;
   localparam logic [2:0] REQ_SYNC      = 3'd5;

   // Frame codes.
   localparam logic [2:0] FR_NONE  = 3'd0;
   localparam logic [2:0] FR_SABM  = 3'd1;
   localparam logic [2:0] FR_SABME = 3'd2;
   localparam logic [2:0] FR_DISC  = 3'd3;
   localparam logic [2:0] FR_DM    = 3'd4;
   localparam logic [2:0] FR_RR    = 3'd5;
   localparam logic [2:0] FR_ENQ   = 3'd6;
   localparam logic [2:0] FR_TMO   = 3'd7;

   // Link states.
   localparam logic [2:0] LS_DISCONNECTED   = 3'd0;
   localparam logic [2:0] LS_AWAIT_CONNECT  = 3'd1;
   localparam logic [2:0] LS_AWAIT_RELEASE  = 3'd2;
   localparam logic [2:0] LS_CONNECTED      = 3'd3;
   localparam logic [2:0] LS_TIMER_RECOVERY = 3'd4;

   // Register indexes.
   localparam logic CSR_RETRY_LIMIT     = 1'b0;
   localparam logic CSR_FALLBACK_WINDOW = 1'b1;

   // Register reset values.
   localparam logic [4:0] RETRY_LIMIT_RESET     = 5'd10;
   localparam logic [2:0] FALLBACK_WINDOW_RESET = 3'd2;

   // One input word.
   typedef struct packed {
      logic [2:0] req_type;
      logic       has_socket;
      logic       sock_teardown;
      logic       sock_listen_dead;
      logic       rx_below_half;
      logic [2:0] sync_state;
      logic       sync_extended;
      logic       sync_own_busy;
      logic       sync_ack_pending;
      logic [6:0] sync_window;
   } req_word_type;

   // One result word.
   typedef struct packed {
      logic [2:0] frame_code;
      logic       link_failed;
      logic       destroy_link;
      logic       restart_t1;
      logic       restart_heartbeat;
      logic       idle_shutdown;
      logic [2:0] new_link_state;
      logic [6:0] current_window;
   } rsp_word_type;

   // Link control state.
   typedef struct packed {
      logic [2:0] link_state;
      logic [4:0] retry_count;
      logic       extended_mode;
      logic [6:0] window_size;
      logic       own_rx_busy;
      logic       ack_pending;
   } link_type;

   // Configuration register values.
   typedef struct packed {
      logic [4:0] retry_limit;
      logic [2:0] fallback_window;
   } cfg_type;

endpackage

// ----- sv/ltr_decide.sv -----
`timescale 1ns / 1ps
// Event decision logic: next link state and result word for one event.
module ltr_decide (
   input  ltr_pkg::req_word_type req,
   input  ltr_pkg::link_type     cur,
   input  ltr_pkg::cfg_type      cfg,
   output ltr_pkg::link_type     nxt,
   output ltr_pkg::rsp_word_type rsp
);

   logic       sock_ok;
   logic       destroy;
   logic       listen_dead;
   logic       at_limit;
   logic [4:0] retry_inc;
   logic [6:0] fb_window;
   logic [6:0] sync_window;
   logic [2:0] frame;
   logic       failed;
   logic       kill;
   logic       t1;
   logic       hb;
   logic       idle;

   // Socket flags only count when a socket is attached.
   assign sock_ok     = req.has_socket;
   assign destroy     = req.has_socket & req.sock_teardown;
   assign listen_dead = req.has_socket & req.sock_listen_dead;
   assign at_limit    = (cur.retry_count == cfg.retry_limit);
   assign retry_inc   = cur.retry_count + 5'd1;

   // A zero window is loaded as one.
   assign fb_window   = (cfg.fallback_window == 3'd0) ? 7'd1 : {4'd0, cfg.fallback_window};
   assign sync_window = (req.sync_window == 7'd0) ? 7'd1 : req.sync_window;

   // Event handling.
   always_comb begin
      nxt    = cur;
      frame  = ltr_pkg::FR_NONE;
      failed = 1'b0;
      kill   = 1'b0;
      t1     = 1'b0;
      hb     = 1'b0;
      idle   = 1'b0;
      case (req.req_type)
         ltr_pkg::REQ_HEARTBEAT: begin
            if (cur.link_state inside {ltr_pkg::LS_DISCONNECTED,
                                       ltr_pkg::LS_AWAIT_RELEASE}) begin
               if (!sock_ok || destroy || listen_dead) begin
                  kill = 1'b1;
               end else begin
                  hb = 1'b1;
               end
            end else begin
               // Clear own busy once the receive buffer has drained.
               if ((cur.link_state inside {ltr_pkg::LS_CONNECTED,
                                           ltr_pkg::LS_TIMER_RECOVERY})
                   && sock_ok && req.rx_below_half && cur.own_rx_busy) begin
                  nxt.own_rx_busy = 1'b0;
                  nxt.ack_pending = 1'b0;
                  frame = ltr_pkg::FR_RR;
               end
               hb = 1'b1;
            end
         end
         ltr_pkg::REQ_T1: begin
            case (cur.link_state)
               ltr_pkg::LS_AWAIT_CONNECT: begin
                  if (at_limit) begin
                     if (!cur.extended_mode) begin
                        failed = 1'b1;
                        nxt.link_state = ltr_pkg::LS_DISCONNECTED;
                     end else begin
                        // Fall back to basic modulus once.
                        nxt.extended_mode = 1'b0;
                        nxt.window_size   = fb_window;
                        nxt.retry_count   = 5'd0;
                        frame = ltr_pkg::FR_SABM;
                        t1 = 1'b1;
                     end
                  end else begin
                     nxt.retry_count = retry_inc;
                     frame = cur.extended_mode ? ltr_pkg::FR_SABME : ltr_pkg::FR_SABM;
                     t1 = 1'b1;
                  end
               end
               ltr_pkg::LS_AWAIT_RELEASE: begin
                  frame = ltr_pkg::FR_DISC;
                  if (at_limit) begin
                     if (!destroy) begin
                        failed = 1'b1;
                        nxt.link_state = ltr_pkg::LS_DISCONNECTED;
                     end
                  end else begin
                     nxt.retry_count = retry_inc;
                     t1 = 1'b1;
                  end
               end
               ltr_pkg::LS_CONNECTED: begin
                  nxt.retry_count = 5'd1;
                  nxt.ack_pending = 1'b0;
                  nxt.link_state  = ltr_pkg::LS_TIMER_RECOVERY;
                  frame = ltr_pkg::FR_ENQ;
                  t1 = 1'b1;
               end
               ltr_pkg::LS_TIMER_RECOVERY: begin
                  if (at_limit) begin
                     frame = ltr_pkg::FR_DM;
                     failed = 1'b1;
                     nxt.link_state = ltr_pkg::LS_DISCONNECTED;
                  end else begin
                     nxt.retry_count = retry_inc;
                     nxt.ack_pending = 1'b0;
                     frame = ltr_pkg::FR_ENQ;
                     t1 = 1'b1;
                  end
               end
               default: begin
                  t1 = 1'b1;
               end
            endcase
         end
         ltr_pkg::REQ_T2: begin
            if (cur.ack_pending) begin
               nxt.ack_pending = 1'b0;
               frame = ltr_pkg::FR_TMO;
            end
         end
         ltr_pkg::REQ_T3: begin
            nxt.retry_count = 5'd0;
            nxt.ack_pending = 1'b0;
            nxt.link_state  = ltr_pkg::LS_TIMER_RECOVERY;
            frame = ltr_pkg::FR_ENQ;
            t1 = 1'b1;
         end
         ltr_pkg::REQ_IDLE: begin
            nxt.retry_count = 5'd0;
            nxt.link_state  = ltr_pkg::LS_AWAIT_RELEASE;
            frame = ltr_pkg::FR_DISC;
            t1 = 1'b1;
            idle = 1'b1;
         end
         ltr_pkg::REQ_SYNC: begin
            // States above the last defined one load as disconnected.
            nxt.link_state    = (req.sync_state > ltr_pkg::LS_TIMER_RECOVERY) ?
                                ltr_pkg::LS_DISCONNECTED : req.sync_state;
            nxt.extended_mode = req.sync_extended;
            nxt.own_rx_busy   = req.sync_own_busy;
            nxt.ack_pending   = req.sync_ack_pending;
            nxt.window_size   = sync_window;
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

   // Result word.
   always_comb begin
      rsp.frame_code        = frame;
      rsp.link_failed       = failed;
      rsp.destroy_link      = kill;
      rsp.restart_t1        = t1;
      rsp.restart_heartbeat = hb;
      rsp.idle_shutdown     = idle;
      rsp.new_link_state    = nxt.link_state;
      rsp.current_window    = nxt.window_size;
   end

endmodule

// ----- sv/link_timer_retry_fsm.sv -----
`timescale 1ns / 1ps
// Top level of the link timer and retry controller.
//
//   channel   direction   handshake             accepted when
//   req_*     in          req_valid/req_stall   req_valid && !req_stall
//   rsp_*     out         rsp_valid/rsp_stall   rsp_valid && !rsp_stall
//   csr_*     in          csr_wr_en             csr_wr_en
//
// A word accepted at an edge is decided from the input register, and its result moves
// to the result register when the result side is free or being emptied: one word in
// every cycle while rsp_stall stays low, the link state register updating as it advances.
// Reset is synchronous and active high; it clears the link state and loads the
// register reset values. A stalled result holds the input register, and a new
// word is still taken whenever the input register empties in the same cycle.
module link_timer_retry_fsm (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_type,
   input  logic       req_has_socket,
   input  logic       req_sock_teardown,
   input  logic       req_sock_listen_dead,
   input  logic       req_rx_below_half,
   input  logic [2:0] req_sync_state,
   input  logic       req_sync_extended,
   input  logic       req_sync_own_busy,
   input  logic       req_sync_ack_pending,
   input  logic [6:0] req_sync_window,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_frame_code,
   output logic       rsp_link_failed,
   output logic       rsp_destroy_link,
   output logic       rsp_restart_t1,
   output logic       rsp_restart_heartbeat,
   output logic       rsp_idle_shutdown,
   output logic [2:0] rsp_new_link_state,
   output logic [6:0] rsp_current_window,
   input  logic       csr_wr_en,
   input  logic       csr_index,
   input  logic [4:0] csr_wdata
);

   `include "link_timer_retry_fsm_assert.svh"

   logic                  in_valid_ff, in_valid_in;
   ltr_pkg::req_word_type in_word_ff;
   ltr_pkg::req_word_type req_word;
   logic                  out_valid_ff, out_valid_in;
   ltr_pkg::rsp_word_type out_word_ff;
   ltr_pkg::link_type     link_ff, link_in;
   ltr_pkg::cfg_type      cfg_ff, cfg_in;
   ltr_pkg::rsp_word_type rsp_word;
   logic                  accept;
   logic                  advance;

   // Gather the input ports into one word.
   always_comb begin
      req_word.req_type         = req_type;
      req_word.has_socket       = req_has_socket;
      req_word.sock_teardown    = req_sock_teardown;
      req_word.sock_listen_dead = req_sock_listen_dead;
      req_word.rx_below_half    = req_rx_below_half;
      req_word.sync_state       = req_sync_state;
      req_word.sync_extended    = req_sync_extended;
      req_word.sync_own_busy    = req_sync_own_busy;
      req_word.sync_ack_pending = req_sync_ack_pending;
      req_word.sync_window      = req_sync_window;
   end

   // Handshake: the input register moves on whenever the result register is
   // free or is being emptied.
   assign advance     = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall   = in_valid_ff && !advance;
   assign accept      = req_valid && !req_stall;
   assign in_valid_in = accept || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   // Decision logic for the word in the input register.
   ltr_decide u_decide (
      .req (in_word_ff),
      .cur (link_ff),
      .cfg (cfg_ff),
      .nxt (link_in),
      .rsp (rsp_word)
   );

   // Configuration register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            ltr_pkg::CSR_RETRY_LIMIT:     cfg_in.retry_limit     = csr_wdata;
            ltr_pkg::CSR_FALLBACK_WINDOW: cfg_in.fallback_window = csr_wdata[2:0];
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff               <= 1'b0;
         out_valid_ff              <= 1'b0;
         cfg_ff.retry_limit        <= ltr_pkg::RETRY_LIMIT_RESET;
         cfg_ff.fallback_window    <= ltr_pkg::FALLBACK_WINDOW_RESET;
         link_ff.link_state        <= ltr_pkg::LS_DISCONNECTED;
         link_ff.retry_count       <= 5'd0;
         link_ff.extended_mode     <= 1'b0;
         link_ff.window_size       <= {4'd0, ltr_pkg::FALLBACK_WINDOW_RESET};
         link_ff.own_rx_busy       <= 1'b0;
         link_ff.ack_pending       <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         cfg_ff       <= cfg_in;
         if (advance) begin
            link_ff <= link_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         in_word_ff <= req_word;
      end
      if (advance) begin
         out_word_ff <= rsp_word;
      end
   end

   // Result ports.
   assign rsp_valid             = out_valid_ff;
   assign rsp_frame_code        = out_word_ff.frame_code;
   assign rsp_link_failed       = out_word_ff.link_failed;
   assign rsp_destroy_link      = out_word_ff.destroy_link;
   assign rsp_restart_t1        = out_word_ff.restart_t1;
   assign rsp_restart_heartbeat = out_word_ff.restart_heartbeat;
   assign rsp_idle_shutdown     = out_word_ff.idle_shutdown;
   assign rsp_new_link_state    = out_word_ff.new_link_state;
   assign rsp_current_window    = out_word_ff.current_window;

   // Checks on the pipeline and the decision logic.
   `LTR_ASSERT_SAME(a_stall_needs_word, clock, reset, req_stall, in_valid_ff && out_valid_ff)
   `LTR_ASSERT_NEXT(a_held_word_stays, clock, reset,
      in_valid_ff && out_valid_ff && rsp_stall, in_valid_ff && $stable(in_word_ff))
   `LTR_ASSERT_SAME(a_fail_disconnects, clock, reset, rsp_valid && rsp_link_failed,
      rsp_new_link_state == ltr_pkg::LS_DISCONNECTED)
   `LTR_ASSERT_SAME(a_window_nonzero, clock, reset, rsp_valid, rsp_current_window != 7'd0)
   `LTR_ASSERT_SAME(a_destroy_no_heartbeat, clock, reset, rsp_valid && rsp_destroy_link,
      !rsp_restart_heartbeat)

endmodule

// ----- tb/link_timer_retry_fsm_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the link timer and retry controller.
module link_timer_retry_fsm_tb;

   localparam int HOLD_CYCLES  = 300;
   localparam int PHASES       = 14;
   localparam int PHASE_WORDS  = 100;
   localparam int SHOWN_ERRORS = 10;

   // One row of the directed table: a register write or an event word.
   typedef struct {
      logic                  is_csr;
      logic                  csr_idx;
      logic [4:0]            csr_val;
      ltr_pkg::req_word_type word;
      logic                  typed;
      ltr_pkg::rsp_word_type result;
   } drill_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [2:0] req_type = '0;
   logic       req_has_socket = 1'b0;
   logic       req_sock_teardown = 1'b0;
   logic       req_sock_listen_dead = 1'b0;
   logic       req_rx_below_half = 1'b0;
   logic [2:0] req_sync_state = '0;
   logic       req_sync_extended = 1'b0;
   logic       req_sync_own_busy = 1'b0;
   logic       req_sync_ack_pending = 1'b0;
   logic [6:0] req_sync_window = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [2:0] rsp_frame_code;
   logic       rsp_link_failed;
   logic       rsp_destroy_link;
   logic       rsp_restart_t1;
   logic       rsp_restart_heartbeat;
   logic       rsp_idle_shutdown;
   logic [2:0] rsp_new_link_state;
   logic [6:0] rsp_current_window;
   logic       csr_wr_en = 1'b0;
   logic       csr_index = 1'b0;
   logic [4:0] csr_wdata = '0;

   // Predicted link state, registers and the results still to arrive.
   ltr_pkg::link_type     link_now;
   ltr_pkg::cfg_type      cfg_now;
   ltr_pkg::rsp_word_type pending_results[$];
   drill_row_type         drill_table[$];

   int  mismatch_count = 0;
   int  words_sent = 0;
   int  csr_writes = 0;
   int  failures_seen = 0;
   int  fallbacks_seen = 0;
   int  stall_left = 0;
   int  hold_left = 0;
   logic hold_req = 1'b0;
   logic hold_done = 1'b0;
   logic calm = 1'b0;

   link_timer_retry_fsm i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_type              (req_type),
      .req_has_socket        (req_has_socket),
      .req_sock_teardown     (req_sock_teardown),
      .req_sock_listen_dead  (req_sock_listen_dead),
      .req_rx_below_half     (req_rx_below_half),
      .req_sync_state        (req_sync_state),
      .req_sync_extended     (req_sync_extended),
      .req_sync_own_busy     (req_sync_own_busy),
      .req_sync_ack_pending  (req_sync_ack_pending),
      .req_sync_window       (req_sync_window),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_frame_code        (rsp_frame_code),
      .rsp_link_failed       (rsp_link_failed),
      .rsp_destroy_link      (rsp_destroy_link),
      .rsp_restart_t1        (rsp_restart_t1),
      .rsp_restart_heartbeat (rsp_restart_heartbeat),
      .rsp_idle_shutdown     (rsp_idle_shutdown),
      .rsp_new_link_state    (rsp_new_link_state),
      .rsp_current_window    (rsp_current_window),
      .csr_wr_en             (csr_wr_en),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   always #1 clock = ~clock;

   // Works out the result of one event word and advances the predicted state.
   function automatic ltr_pkg::rsp_word_type next_link_result(ltr_pkg::req_word_type w);
      ltr_pkg::rsp_word_type r;
      logic sk;
      logic destroy;
      logic listen_dead;
      r = '0;
      sk = w.has_socket;
      destroy = sk & w.sock_teardown;
      listen_dead = sk & w.sock_listen_dead;
      case (w.req_type)
         ltr_pkg::REQ_HEARTBEAT: begin
            if (link_now.link_state == ltr_pkg::LS_DISCONNECTED ||
                link_now.link_state == ltr_pkg::LS_AWAIT_RELEASE) begin
               if (!sk || destroy || listen_dead) r.destroy_link = 1'b1;
               else r.restart_heartbeat = 1'b1;
            end else begin
               // A busy receiver that has drained below half announces it is ready.
               if ((link_now.link_state == ltr_pkg::LS_CONNECTED ||
                    link_now.link_state == ltr_pkg::LS_TIMER_RECOVERY) &&
                   sk && w.rx_below_half && link_now.own_rx_busy) begin
                  link_now.own_rx_busy = 1'b0;
                  link_now.ack_pending = 1'b0;
                  r.frame_code = ltr_pkg::FR_RR;
               end
               r.restart_heartbeat = 1'b1;
            end
         end
         ltr_pkg::REQ_T1: begin
            case (link_now.link_state)
               ltr_pkg::LS_AWAIT_CONNECT: begin
                  if (link_now.retry_count == cfg_now.retry_limit) begin
                     if (!link_now.extended_mode) begin
                        r.link_failed = 1'b1;
                        link_now.link_state = ltr_pkg::LS_DISCONNECTED;
                     end else begin
                        // Give up on the extended modulus once and retry in basic.
                        link_now.extended_mode = 1'b0;
                        link_now.window_size = (cfg_now.fallback_window != '0) ?
                                               {4'd0, cfg_now.fallback_window} : 7'd1;
                        link_now.retry_count = '0;
                        r.frame_code = ltr_pkg::FR_SABM;
                        r.restart_t1 = 1'b1;
                        fallbacks_seen++;
                     end
                  end else begin
                     link_now.retry_count = link_now.retry_count + 5'd1;
                     r.frame_code = link_now.extended_mode ? ltr_pkg::FR_SABME :
                                                             ltr_pkg::FR_SABM;
                     r.restart_t1 = 1'b1;
                  end
               end
               ltr_pkg::LS_AWAIT_RELEASE: begin
                  r.frame_code = ltr_pkg::FR_DISC;
                  if (link_now.retry_count == cfg_now.retry_limit) begin
                     if (!destroy) begin
                        r.link_failed = 1'b1;
                        link_now.link_state = ltr_pkg::LS_DISCONNECTED;
                     end
                  end else begin
                     link_now.retry_count = link_now.retry_count + 5'd1;
                     r.restart_t1 = 1'b1;
                  end
               end
               ltr_pkg::LS_CONNECTED: begin
                  link_now.retry_count = 5'd1;
                  link_now.ack_pending = 1'b0;
                  r.frame_code = ltr_pkg::FR_ENQ;
                  r.restart_t1 = 1'b1;
                  link_now.link_state = ltr_pkg::LS_TIMER_RECOVERY;
               end
               ltr_pkg::LS_TIMER_RECOVERY: begin
                  if (link_now.retry_count == cfg_now.retry_limit) begin
                     r.frame_code = ltr_pkg::FR_DM;
                     r.link_failed = 1'b1;
                     link_now.link_state = ltr_pkg::LS_DISCONNECTED;
                  end else begin
                     link_now.retry_count = link_now.retry_count + 5'd1;
                     link_now.ack_pending = 1'b0;
                     r.frame_code = ltr_pkg::FR_ENQ;
                     r.restart_t1 = 1'b1;
                  end
               end
               default: r.restart_t1 = 1'b1;
            endcase
         end
         ltr_pkg::REQ_T2: begin
            if (link_now.ack_pending) begin
               link_now.ack_pending = 1'b0;
               r.frame_code = ltr_pkg::FR_TMO;
            end
         end
         ltr_pkg::REQ_T3: begin
            link_now.retry_count = '0;
            link_now.ack_pending = 1'b0;
            r.frame_code = ltr_pkg::FR_ENQ;
            r.restart_t1 = 1'b1;
            link_now.link_state = ltr_pkg::LS_TIMER_RECOVERY;
         end
         ltr_pkg::REQ_IDLE: begin
            link_now.retry_count = '0;
            link_now.link_state = ltr_pkg::LS_AWAIT_RELEASE;
            r.frame_code = ltr_pkg::FR_DISC;
            r.restart_t1 = 1'b1;
            r.idle_shutdown = 1'b1;
         end
         ltr_pkg::REQ_SYNC: begin
            link_now.link_state = (w.sync_state > ltr_pkg::LS_TIMER_RECOVERY) ?
                                  ltr_pkg::LS_DISCONNECTED : w.sync_state;
            link_now.extended_mode = w.sync_extended;
            link_now.own_rx_busy = w.sync_own_busy;
            link_now.ack_pending = w.sync_ack_pending;
            link_now.window_size = (w.sync_window != '0) ? w.sync_window : 7'd1;
         end
         default: ;
      endcase
      if (r.link_failed) failures_seen++;
      r.new_link_state = link_now.link_state;
      r.current_window = link_now.window_size;
      return r;
   endfunction

   function automatic ltr_pkg::req_word_type make_event(logic [2:0] kind, logic sk,
                                                        logic dest, logic ld, logic below,
                                                        logic [2:0] st, logic ext,
                                                        logic busy, logic ack,
                                                        logic [6:0] win);
      ltr_pkg::req_word_type w;
      w.req_type = kind;
      w.has_socket = sk;
      w.sock_teardown = dest;
      w.sock_listen_dead = ld;
      w.rx_below_half = below;
      w.sync_state = st;
      w.sync_extended = ext;
      w.sync_own_busy = busy;
      w.sync_ack_pending = ack;
      w.sync_window = win;
      return w;
   endfunction

   function automatic ltr_pkg::rsp_word_type make_result(logic [2:0] frame, logic failed,
                                                         logic kill, logic t1, logic hb,
                                                         logic idle, logic [2:0] ls,
                                                         logic [6:0] win);
      ltr_pkg::rsp_word_type r;
      r.frame_code = frame;
      r.link_failed = failed;
      r.destroy_link = kill;
      r.restart_t1 = t1;
      r.restart_heartbeat = hb;
      r.idle_shutdown = idle;
      r.new_link_state = ls;
      r.current_window = win;
      return r;
   endfunction

   function automatic drill_row_type event_row(ltr_pkg::req_word_type w, logic typed,
                                               ltr_pkg::rsp_word_type r);
      drill_row_type row;
      row.is_csr = 1'b0;
      row.csr_idx = 1'b0;
      row.csr_val = '0;
      row.word = w;
      row.typed = typed;
      row.result = r;
      return row;
   endfunction

   function automatic drill_row_type csr_row(logic idx, logic [4:0] val);
      drill_row_type row;
      row = event_row('0, 1'b0, '0);
      row.is_csr = 1'b1;
      row.csr_idx = idx;
      row.csr_val = val;
      return row;
   endfunction

   // Idle stretches: mostly none or short, now and then long.
   function automatic int gap_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 85) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // Random word; the event type is forced to T1 with the given percentage, else random.
   function automatic ltr_pkg::req_word_type random_event(int t1_percent);
      logic [31:0] bits;
      ltr_pkg::req_word_type w;
      bits = $urandom;
      w = bits[$bits(ltr_pkg::req_word_type)-1:0];
      if ($urandom_range(0, 99) < t1_percent) w.req_type = ltr_pkg::REQ_T1;
      else w.req_type = bits[31:29];
      return w;
   endfunction

   task automatic flag_error(string msg);
      mismatch_count++;
      if (mismatch_count <= SHOWN_ERRORS) $display("ERROR at %0t ns: %s", $realtime, msg);
   endtask

   task automatic check_field(string name, logic [6:0] want, logic [6:0] got);
      if (got !== want)
         flag_error($sformatf("%s expected %0d, got %0d", name, want, got));
   endtask

   // Compares one accepted result word with the oldest prediction.
   task automatic check_result();
      ltr_pkg::rsp_word_type want;
      if (pending_results.size() == 0) begin
         flag_error("result word arrived with nothing expected");
      end else begin
         want = pending_results.pop_front();
         check_field("frame_code", 7'(want.frame_code), 7'(rsp_frame_code));
         check_field("link_failed", 7'(want.link_failed), 7'(rsp_link_failed));
         check_field("destroy_link", 7'(want.destroy_link), 7'(rsp_destroy_link));
         check_field("restart_t1", 7'(want.restart_t1), 7'(rsp_restart_t1));
         check_field("restart_heartbeat", 7'(want.restart_heartbeat),
                     7'(rsp_restart_heartbeat));
         check_field("idle_shutdown", 7'(want.idle_shutdown), 7'(rsp_idle_shutdown));
         check_field("new_link_state", 7'(want.new_link_state), 7'(rsp_new_link_state));
         check_field("current_window", want.current_window, rsp_current_window);
      end
   endtask

   // Offers one word until it is taken, then records what it should produce.
   task automatic send_word(ltr_pkg::req_word_type w, logic typed,
                            ltr_pkg::rsp_word_type r);
      ltr_pkg::rsp_word_type predicted;
      req_valid <= 1'b1;
      req_type <= w.req_type;
      req_has_socket <= w.has_socket;
      req_sock_teardown <= w.sock_teardown;
      req_sock_listen_dead <= w.sock_listen_dead;
      req_rx_below_half <= w.rx_below_half;
      req_sync_state <= w.sync_state;
      req_sync_extended <= w.sync_extended;
      req_sync_own_busy <= w.sync_own_busy;
      req_sync_ack_pending <= w.sync_ack_pending;
      req_sync_window <= w.sync_window;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = next_link_result(w);
      pending_results.push_back(typed ? r : predicted);
      words_sent++;
   endtask

   task automatic pause_sender();
      int n;
      n = calm ? 0 : gap_length();
      if (n != 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Stops offering words and waits until every predicted result has come back.
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // One register write; the enable drops again before the next write.
   task automatic write_register(logic idx, logic [4:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == ltr_pkg::CSR_RETRY_LIMIT) cfg_now.retry_limit = val;
      else cfg_now.fallback_window = val[2:0];
      csr_writes++;
      @(posedge clock);
   endtask

   // Receiver: checks accepted results and stalls at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) check_result();
         if (hold_left != 0) begin
            rsp_stall <= 1'b1;
         end else if (stall_left != 0) begin
            rsp_stall <= 1'b1;
            stall_left <= stall_left - 1;
         end else begin
            int n;
            n = calm ? 0 : gap_length();
            rsp_stall <= (n != 0);
            stall_left <= (n != 0) ? n - 1 : 0;
         end
      end
   end

   // Long hold-off of the result side, counted here once it is requested.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_req && !hold_done) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end
   end

   initial begin
      #1_000_000;
      $display("Timed out with %0d results outstanding", pending_results.size());
      $display("link_timer_retry_fsm test failed");
      $finish;
   end

   initial begin
      int words_in_phase;
      int scenario_len;
      ltr_pkg::req_word_type w;

      link_now = '0;
      link_now.window_size = {4'd0, ltr_pkg::FALLBACK_WINDOW_RESET};
      cfg_now.retry_limit = ltr_pkg::RETRY_LIMIT_RESET;
      cfg_now.fallback_window = ltr_pkg::FALLBACK_WINDOW_RESET;

      // Directed table: reset values, socket cases, unknown codes, retry, fallback and failure paths.
      drill_table.push_back(event_row(
         make_event(ltr_pkg::REQ_HEARTBEAT, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
         make_result(ltr_pkg::FR_NONE, 0, 1, 0, 0, 0, ltr_pkg::LS_DISCONNECTED, 7'd2)));
      drill_table.push_back(event_row(
         make_event(ltr_pkg::REQ_HEARTBEAT, 1, 0, 0, 1, 0, 0, 0, 0, 0), 1,
         make_result(ltr_pkg::FR_NONE, 0, 0, 0, 1, 0, ltr_pkg::LS_DISCONNECTED, 7'd2)));
      drill_table.push_back(event_row(
         make_event(ltr_pkg::REQ_HEARTBEAT, 0, 1, 1, 0, 0, 0, 0, 0, 0), 1,
         make_result(ltr_pkg::FR_NONE, 0, 1, 0, 0, 0, ltr_pkg::LS_DISCONNECTED, 7'd2)));
      drill_table.push_back(event_row(
         make_event(ltr_pkg::REQ_T1, 1, 0, 0, 0, 0, 0, 0, 0, 0), 1,
         make_result(ltr_pkg::FR_NONE, 0, 0, 1, 0, 0, ltr_pkg::LS_DISCONNECTED, 7'd2)));
      drill_table.push_back(event_row(
         make_event(3'd6, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
         make_result(ltr_pkg::FR_NONE, 0, 0, 0, 0, 0, ltr_pkg::LS_DISCONNECTED, 7'd2)));
      drill_table.push_back(event_row(
         make_event(3'd7, 1, 1, 1, 1, 7, 1, 1, 1, 127), 1,
         make_result(ltr_pkg::FR_NONE, 0, 0, 0, 0, 0, ltr_pkg::LS_DISCONNECTED, 7'd2)));
      drill_table.push_back(event_row(
         make_event(ltr_pkg::REQ_SYNC, 1, 1, 1, 1, 7, 1, 1, 1, 0), 1,
         make_result(ltr_pkg::FR_NONE, 0, 0, 0, 0, 0, ltr_pkg::LS_DISCONNECTED, 7'd1)));
      drill_table.push_back(event_row(
         make_event(ltr_pkg::REQ_T2, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
         make_result(ltr_pkg::FR_TMO, 0, 0, 0, 0, 0, ltr_pkg::LS_DISCONNECTED, 7'd1)));
      drill_table.push_back(csr_row(ltr_pkg::CSR_RETRY_LIMIT, 5'd1));
      drill_table.push_back(csr_row(ltr_pkg::CSR_FALLBACK_WINDOW, 5'b11000));
      drill_table.push_back(event_row(
         make_event(ltr_pkg::REQ_SYNC, 0, 0, 0, 0, 1, 1, 0, 0, 127), 1,
         make_result(ltr_pkg::FR_NONE, 0, 0, 0, 0, 0, ltr_pkg::LS_AWAIT_CONNECT, 7'd127)));
      drill_table.push_back(event_row(
         make_event(ltr_pkg::REQ_T1, 1, 0, 0, 0, 0, 0, 0, 0, 0), 1,
         make_result(ltr_pkg::FR_SABME, 0, 0, 1, 0, 0, ltr_pkg::LS_AWAIT_CONNECT, 7'd127)));
      drill_table.push_back(event_row(
         make_event(ltr_pkg::REQ_T1, 1, 0, 0, 0, 0, 0, 0, 0, 0), 1,
         make_result(ltr_pkg::FR_SABM, 0, 0, 1, 0, 0, ltr_pkg::LS_AWAIT_CONNECT, 7'd1)));
      drill_table.push_back(event_row(
         make_event(ltr_pkg::REQ_T1, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0));
      drill_table.push_back(event_row(
         make_event(ltr_pkg::REQ_T1, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
         make_result(ltr_pkg::FR_NONE, 1, 0, 0, 0, 0, ltr_pkg::LS_DISCONNECTED, 7'd1)));
      drill_table.push_back(event_row(
         make_event(ltr_pkg::REQ_SYNC, 0, 0, 0, 0, 2, 0, 0, 0, 5), 1,
         make_result(ltr_pkg::FR_NONE, 0, 0, 0, 0, 0, ltr_pkg::LS_AWAIT_RELEASE, 7'd5)));
      drill_table.push_back(event_row(
         make_event(ltr_pkg::REQ_T1, 1, 1, 0, 0, 0, 0, 0, 0, 0), 0, '0));
      drill_table.push_back(event_row(
         make_event(ltr_pkg::REQ_T1, 0, 1, 0, 0, 0, 0, 0, 0, 0), 0, '0));
      drill_table.push_back(event_row(
         make_event(ltr_pkg::REQ_SYNC, 0, 0, 0, 0, 3, 0, 1, 1, 64), 0, '0));
      drill_table.push_back(event_row(
         make_event(ltr_pkg::REQ_HEARTBEAT, 1, 0, 0, 1, 0, 0, 0, 0, 0), 0, '0));
      drill_table.push_back(event_row(
         make_event(ltr_pkg::REQ_T1, 1, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0));
      drill_table.push_back(event_row(
         make_event(ltr_pkg::REQ_T1, 1, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0));
      drill_table.push_back(event_row(
         make_event(ltr_pkg::REQ_T3, 1, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0));
      drill_table.push_back(event_row(
         make_event(ltr_pkg::REQ_T1, 1, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0));
      drill_table.push_back(event_row(
         make_event(ltr_pkg::REQ_IDLE, 1, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0));
      drill_table.push_back(event_row(
         make_event(ltr_pkg::REQ_HEARTBEAT, 1, 0, 1, 0, 0, 0, 0, 0, 0), 0, '0));
      drill_table.push_back(csr_row(ltr_pkg::CSR_RETRY_LIMIT, 5'd31));
      drill_table.push_back(csr_row(ltr_pkg::CSR_FALLBACK_WINDOW, 5'd7));

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (drill_table[i]) begin
         if (drill_table[i].is_csr) begin
            drain();
            write_register(drill_table[i].csr_idx, drill_table[i].csr_val);
         end else begin
            send_word(drill_table[i].word, drill_table[i].typed, drill_table[i].result);
            pause_sender();
         end
      end

      // Random phases: each starts with new register values, then runs
      // sync-led scenarios that mostly fire T1 to walk the retry paths.
      for (int phase = 0; phase < PHASES; phase++) begin
         drain();
         case (phase)
            0: begin
               write_register(ltr_pkg::CSR_RETRY_LIMIT, 5'd1);
               write_register(ltr_pkg::CSR_FALLBACK_WINDOW, 5'd0);
            end
            1: begin
               write_register(ltr_pkg::CSR_RETRY_LIMIT, 5'd31);
               write_register(ltr_pkg::CSR_FALLBACK_WINDOW, 5'd7);
            end
            2: begin
               write_register(ltr_pkg::CSR_RETRY_LIMIT, 5'd0);
               write_register(ltr_pkg::CSR_FALLBACK_WINDOW, 5'($urandom_range(0, 31)));
               hold_req <= 1'b1;
            end
            default: begin
               if ($urandom_range(0, 9) < 7)
                  write_register(ltr_pkg::CSR_RETRY_LIMIT, 5'($urandom_range(1, 6)));
               else
                  write_register(ltr_pkg::CSR_RETRY_LIMIT, 5'($urandom_range(0, 31)));
               write_register(ltr_pkg::CSR_FALLBACK_WINDOW, 5'($urandom_range(0, 31)));
            end
         endcase
         words_in_phase = 0;
         while (words_in_phase < PHASE_WORDS) begin
            calm <= (phase == 2) || ($urandom_range(0, 5) == 0);
            w = random_event(0);
            w.req_type = ltr_pkg::REQ_SYNC;
            if ($urandom_range(0, 4) != 0)
               w.sync_state = {1'b0, 2'($urandom_range(0, 3))} + 3'd1;
            send_word(w, 1'b0, '0);
            pause_sender();
            words_in_phase++;
            scenario_len = $urandom_range(1, 2 * cfg_now.retry_limit + 6);
            for (int k = 0; k < scenario_len; k++) begin
               w = random_event(70);
               send_word(w, 1'b0, '0);
               pause_sender();
               if (w.req_type <= ltr_pkg::REQ_SYNC) words_in_phase++;
            end
         end
      end

      drain();
      calm <= 1'b0;
      repeat (8) @(posedge clock);
      $display("Ran %0d event words and %0d register writes under %0d register settings.",
               words_sent, csr_writes, PHASES + 3);
      $display("Predicted %0d link failures and %0d modulus fallbacks; %0d mismatches.",
               failures_seen, fallbacks_seen, mismatch_count);
      if (mismatch_count == 0) begin
         $display("link_timer_retry_fsm test passed");
      end else begin
         $display("link_timer_retry_fsm test failed");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+sv
sv/ltr_pkg.sv
sv/ltr_decide.sv
sv/link_timer_retry_fsm.sv
tb/link_timer_retry_fsm_tb.sv
